FILE: src/rce_pkg.sv
// shared types, constants and helpers of the register calculator executor
// no dependencies; used by the top level, rce_ctrl and rce_dp through scoped names
package rce_pkg;

	localparam int NUM_REGS  = 16;
	localparam int IDX_W     = $clog2(NUM_REGS);
	localparam int DATA_W    = 64;
	localparam int FRAC_BITS = 32;
	localparam int CNT_W     = 6;

	localparam logic [DATA_W-1:0] SIGN_VAL = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic [DATA_W-1:0] MAX_POS  = {1'b0, {(DATA_W-1){1'b1}}};

	localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(4);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DATA_W - 1);

	localparam logic [1:0] ADDR_FINAL_REG = 2'd0;

	typedef enum logic [3:0] {
		K_CONST = 4'd0,
		K_VAR   = 4'd1,
		K_ADD   = 4'd2,
		K_SUB   = 4'd3,
		K_MUL   = 4'd4,
		K_DIV   = 4'd5,
		K_NEG   = 4'd6,
		K_AND   = 4'd7,
		K_OR    = 4'd8,
		K_XOR   = 4'd9,
		K_MOD   = 4'd10,
		K_SHL   = 4'd11,
		K_SHR   = 4'd12
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_DIV0 = 2'd1,
		ST_MOD0 = 2'd2,
		ST_OVF  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		RD_LEFT  = 2'd0,
		RD_RIGHT = 2'd1,
		RD_FINAL = 2'd2
	} rd_sel_t;

	// controller to datapath
	typedef struct packed {
		logic             load;
		rd_sel_t          rd_sel;
		logic             cap_a;
		logic             cap_b;
		logic             prep;
		logic             op;
		logic             mul_step;
		logic             div_step;
		logic [CNT_W-1:0] cnt;
		logic             mfin;
		logic             dfin;
		logic             toq;
		logic             sat;
		logic             wr;
		logic             out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		kind_t kind;
		logic  last;
		logic  sticky;
		logic  zero;
		logic  out_busy;
	} sts_t;

	function automatic logic [IDX_W-1:0] reduce_idx(input logic [3:0] x);
		logic [7:0] t;
		t = 8'(x) % 8'(NUM_REGS);
		return IDX_W'(t);
	endfunction

	function automatic logic [DATA_W-1:0] mag_of(input logic [DATA_W-1:0] v);
		return v[DATA_W-1] ? (DATA_W'(0) - v) : v;
	endfunction

endpackage

FILE: src/rce_in_if.sv
// instruction channel: valid/ready handshake plus one instruction word
// depends on nothing
interface rce_in_if;
	logic        valid;
	logic        ready;
	logic [3:0]  kind;
	logic [3:0]  dest;
	logic [3:0]  left;
	logic [3:0]  right;
	logic [63:0] value;
	logic        last;

	modport source(output valid, kind, dest, left, right, value, last, input ready);
	modport sink(input valid, kind, dest, left, right, value, last, output ready);
endinterface

FILE: src/rce_out_if.sv
// result channel: valid/ready handshake plus final value and status
// depends on nothing
interface rce_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] final_value;
	logic [1:0]  status;

	modport source(output valid, final_value, status, input ready);
	modport sink(input valid, final_value, status, output ready);
endinterface

FILE: src/register_calculator_executor.sv
// top level of the register calculator executor: apb register, controller
// and datapath; depends on rce_pkg, rce_in_if, rce_out_if, rce_ctrl, rce_dp
//
// channel  | dir | word
// instr    | in  | kind, dest, left, right, value (q32.32), last
// result   | out | final_value (q32.32), status
// apb      | in  | final_register at byte 0
//
// load, add, sub and neg go straight from execute to write; the bitwise ops and
// shifts pass through conversion and saturation, multiply sums four 32x32 partial
// products, divide and modulo take one quotient bit per cycle in the shared divider;
// a skipped instruction and a zero divisor end without a write. a last instruction
// adds a read of the answer register. reset clears the sequencer, the status and the
// per-register valid bits, so the register file reads as zero at once.
// a last instruction waits in its final phase while an earlier result word
// is still untaken; no new instruction is taken until the current one is done.
module register_calculator_executor (
	input  logic        clk,
	input  logic        arst_n,
	rce_in_if.sink      instr,
	rce_out_if.source   result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	rce_pkg::cmd_t cmd;
	rce_pkg::sts_t sts;
	logic [3:0]    final_q;

	assign pready = 1'b1;
	assign prdata = (paddr == rce_pkg::ADDR_FINAL_REG) ? {28'd0, final_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			final_q <= '0;
		end else if (psel && penable && pwrite && paddr == rce_pkg::ADDR_FINAL_REG) begin
			final_q <= pwdata[3:0];
		end
	end

	rce_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (instr.valid),
		.in_ready (instr.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rce_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.kind        (instr.kind),
		.dest        (instr.dest),
		.left        (instr.left),
		.right       (instr.right),
		.value       (instr.value),
		.last        (instr.last),
		.final_reg   (final_q),
		.out_valid   (result.valid),
		.out_ready   (result.ready),
		.final_value (result.final_value),
		.status      (result.status)
	);

	// phase commands never overlap
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.cap_a, cmd.cap_b, cmd.prep, cmd.op, cmd.wr, cmd.out_load}))
		else $error("overlapping datapath commands");

	// a result word only follows an instruction marked last
	a_out_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.last)
		else $error("result produced for a non-last instruction");

	// divide or modulo error blocks all writes
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr |-> !sts.sticky)
		else $error("register written while error is sticky");

	// one instruction at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(instr.valid && instr.ready) |=> !instr.ready)
		else $error("second instruction taken during execution");
endmodule

FILE: src/rce_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module rce_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: src/rce_ctrl.sv
// sequencer of the executor: steps each instruction through read, execute,
// write and result phases; depends on rce_pkg
module rce_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rce_pkg::sts_t sts,
	output rce_pkg::cmd_t cmd
);
	typedef enum logic [15:0] {
		S_IDLE = 16'h0001,
		S_RDA  = 16'h0002,
		S_RDB  = 16'h0004,
		S_CAPB = 16'h0008,
		S_PREP = 16'h0010,
		S_OP   = 16'h0020,
		S_MUL  = 16'h0040,
		S_DIV  = 16'h0080,
		S_MFIN = 16'h0100,
		S_DFIN = 16'h0200,
		S_TOQ  = 16'h0400,
		S_SAT  = 16'h0800,
		S_WR   = 16'h1000,
		S_FIN  = 16'h2000,
		S_RDF  = 16'h4000,
		S_SKIP = 16'h8000
	} state_t;

	state_t                     state_q, state_d;
	logic [rce_pkg::CNT_W-1:0]  cnt_q, cnt_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		cmd.rd_sel = rce_pkg::RD_LEFT;
		cmd.cnt    = cnt_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_RDA;
				end
			end
			S_RDA: begin
				cmd.rd_sel = rce_pkg::RD_LEFT;
				if (sts.sticky || sts.kind > rce_pkg::K_SHR) begin
					state_d = S_FIN;
				end else begin
					state_d = S_RDB;
				end
			end
			S_RDB: begin
				cmd.rd_sel = rce_pkg::RD_RIGHT;
				cmd.cap_a  = 1'b1;
				state_d    = S_CAPB;
			end
			S_CAPB: begin
				cmd.cap_b = 1'b1;
				state_d   = S_PREP;
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = S_OP;
			end
			S_OP: begin
				cmd.op = 1'b1;
				cnt_d  = '0;
				case (sts.kind)
					rce_pkg::K_CONST, rce_pkg::K_VAR, rce_pkg::K_ADD,
					rce_pkg::K_SUB, rce_pkg::K_NEG: state_d = S_WR;
					rce_pkg::K_MUL: state_d = S_MUL;
					rce_pkg::K_DIV, rce_pkg::K_MOD: begin
						// zero divisor: error is latched, nothing written
						state_d = sts.zero ? S_FIN : S_DIV;
					end
					default: state_d = S_TOQ;
				endcase
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				if (cnt_q == rce_pkg::MUL_LAST) begin
					state_d = S_MFIN;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == rce_pkg::DIV_LAST) begin
					state_d = S_DFIN;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_MFIN: begin
				cmd.mfin = 1'b1;
				state_d  = S_SAT;
			end
			S_DFIN: begin
				cmd.dfin = 1'b1;
				state_d  = S_SAT;
			end
			S_TOQ: begin
				cmd.toq = 1'b1;
				state_d = S_SAT;
			end
			S_SAT: begin
				cmd.sat = 1'b1;
				state_d = S_WR;
			end
			S_WR: begin
				cmd.wr  = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				cmd.rd_sel = rce_pkg::RD_FINAL;
				if (!sts.last) begin
					state_d = S_IDLE;
				end else if (!sts.out_busy) begin
					state_d = S_RDF;
				end
			end
			S_RDF: begin
				cmd.out_load = 1'b1;
				state_d      = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end
endmodule

FILE: src/rce_dp.sv
// datapath: register file, operand registers, a multiply unit, a divide unit shared
// by divide and modulo, saturation and result register; depends on rce_pkg and rce_ram
module rce_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rce_pkg::cmd_t                 cmd,
	output rce_pkg::sts_t                 sts,
	input  logic [3:0]                    kind,
	input  logic [3:0]                    dest,
	input  logic [3:0]                    left,
	input  logic [3:0]                    right,
	input  logic [rce_pkg::DATA_W-1:0]    value,
	input  logic                          last,
	input  logic [3:0]                    final_reg,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rce_pkg::DATA_W-1:0]    final_value,
	output logic [1:0]                    status
);
	localparam int W  = rce_pkg::DATA_W;
	localparam int F  = rce_pkg::FRAC_BITS;
	localparam int HW = W / 2;

	rce_pkg::kind_t             kind_q;
	logic [rce_pkg::IDX_W-1:0]  dest_q, left_q, right_q, raddr;
	logic [W-1:0]               value_q;
	logic                       last_q;
	logic [W-1:0]               a_q, b_q, ia_q, ib_q, x_q, y_q, t_q, m_q, res_q;
	logic                       sign_q, neg_q, big_q, ovf_q;
	logic [1:0]                 err_q;
	logic [rce_pkg::NUM_REGS-1:0] vld_q;
	logic                       rvld_q;
	logic [W-1:0]               rdata, rd_val;
	logic [2*W-1:0]             acc_q;
	logic [W-1:0]               p_q;
	logic [1:0]                 sh_q;
	logic [W-1:0]               rem_q, num_q, dvs_q, quo_q;
	logic                       out_valid_q;
	logic [W-1:0]               out_value_q;
	logic [1:0]                 out_status_q;

	// combinational helpers
	logic [W-1:0]   ma, mb, ipa, ipb, sum, dif, t_d, mt, ma_i, mb_i, nhi;
	logic [HW-1:0]  mx, my;
	logic [W:0]     r2, r2_sub;
	logic [2*W-1:0] p_ext;
	logic           oor;

	rce_ram #(.WIDTH(W), .DEPTH(rce_pkg::NUM_REGS)) u_regs (
		.clk   (clk),
		.we    (cmd.wr),
		.waddr (dest_q),
		.wdata (res_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		case (cmd.rd_sel)
			rce_pkg::RD_RIGHT: raddr = right_q;
			rce_pkg::RD_FINAL: raddr = rce_pkg::reduce_idx(final_reg);
			default:           raddr = left_q;
		endcase
	end

	// never-written registers read as zero
	assign rd_val = rvld_q ? rdata : '0;

	always_comb begin
		ma  = rce_pkg::mag_of(a_q);
		mb  = rce_pkg::mag_of(b_q);
		ipa = ma >> F;
		ipb = mb >> F;
		sum = a_q + b_q;
		dif = a_q - b_q;
		ma_i = rce_pkg::mag_of(ia_q);
		mb_i = rce_pkg::mag_of(ib_q);
		nhi  = x_q >> (W - F);
		oor  = ib_q[W-1] || (ib_q > W'(W - 1));
		case (kind_q)
			rce_pkg::K_AND: t_d = ia_q & ib_q;
			rce_pkg::K_OR:  t_d = ia_q | ib_q;
			rce_pkg::K_XOR: t_d = ia_q ^ ib_q;
			rce_pkg::K_SHL: t_d = oor ? '0 : (ia_q << ib_q[5:0]);
			rce_pkg::K_SHR: t_d = oor ? {W{ia_q[W-1]}} : W'($signed(ia_q) >>> ib_q[5:0]);
			default:        t_d = '0;
		endcase
		mt = rce_pkg::mag_of(t_q);
		case (cmd.cnt[1:0])
			2'd0:    begin mx = x_q[HW-1:0]; my = y_q[HW-1:0]; end
			2'd1:    begin mx = x_q[HW-1:0]; my = y_q[W-1:HW]; end
			2'd2:    begin mx = x_q[W-1:HW]; my = y_q[HW-1:0]; end
			default: begin mx = x_q[W-1:HW]; my = y_q[W-1:HW]; end
		endcase
		case (sh_q)
			2'd0:    p_ext = {{W{1'b0}}, p_q};
			2'd1:    p_ext = {{HW{1'b0}}, p_q, {HW{1'b0}}};
			default: p_ext = {p_q, {W{1'b0}}};
		endcase
		r2     = {rem_q, num_q[W-1]};
		r2_sub = r2 - {1'b0, dvs_q};
	end

	always_ff @(posedge clk) begin
		rvld_q <= vld_q[raddr];
		if (cmd.load) begin
			kind_q  <= rce_pkg::kind_t'(kind);
			dest_q  <= rce_pkg::reduce_idx(dest);
			left_q  <= rce_pkg::reduce_idx(left);
			right_q <= rce_pkg::reduce_idx(right);
			value_q <= value;
			last_q  <= last;
		end
		if (cmd.cap_a) a_q <= rd_val;
		if (cmd.cap_b) b_q <= rd_val;
		if (cmd.prep) begin
			x_q    <= ma;
			y_q    <= mb;
			sign_q <= a_q[W-1] ^ b_q[W-1];
			ia_q   <= a_q[W-1] ? (W'(0) - ipa) : ipa;
			ib_q   <= b_q[W-1] ? (W'(0) - ipb) : ipb;
		end
		if (cmd.op) begin
			t_q   <= t_d;
			acc_q <= '0;
			case (kind_q)
				rce_pkg::K_CONST, rce_pkg::K_VAR: begin
					ovf_q <= 1'b0;
					res_q <= value_q;
				end
				rce_pkg::K_ADD: begin
					if ((a_q[W-1] ^ sum[W-1]) && (b_q[W-1] ^ sum[W-1])) begin
						ovf_q <= 1'b1;
						res_q <= a_q[W-1] ? rce_pkg::SIGN_VAL : rce_pkg::MAX_POS;
					end else begin
						ovf_q <= 1'b0;
						res_q <= sum;
					end
				end
				rce_pkg::K_SUB: begin
					if ((a_q[W-1] ^ b_q[W-1]) && (a_q[W-1] ^ dif[W-1])) begin
						ovf_q <= 1'b1;
						res_q <= a_q[W-1] ? rce_pkg::SIGN_VAL : rce_pkg::MAX_POS;
					end else begin
						ovf_q <= 1'b0;
						res_q <= dif;
					end
				end
				rce_pkg::K_NEG: begin
					if (a_q == rce_pkg::SIGN_VAL) begin
						ovf_q <= 1'b1;
						res_q <= rce_pkg::MAX_POS;
					end else begin
						ovf_q <= 1'b0;
						res_q <= W'(0) - a_q;
					end
				end
				rce_pkg::K_DIV: begin
					// quotient overflows 64 bits exactly when the high half reaches the divisor
					ovf_q <= 1'b0;
					rem_q <= nhi;
					big_q <= (nhi >= y_q);
					num_q <= x_q << F;
					dvs_q <= y_q;
					quo_q <= '0;
					neg_q <= sign_q;
				end
				rce_pkg::K_MOD: begin
					ovf_q <= 1'b0;
					rem_q <= '0;
					big_q <= 1'b0;
					num_q <= ma_i;
					dvs_q <= mb_i;
					quo_q <= '0;
					neg_q <= ia_q[W-1];
				end
				default: begin
					ovf_q <= 1'b0;
					res_q <= res_q;
				end
			endcase
		end
		if (cmd.mul_step) begin
			if (cmd.cnt != rce_pkg::MUL_LAST) begin
				p_q  <= W'(mx) * W'(my);
				sh_q <= (cmd.cnt[1:0] == 2'd0) ? 2'd0 :
				        (cmd.cnt[1:0] == 2'd3) ? 2'd2 : 2'd1;
			end
			if (cmd.cnt != '0) begin
				acc_q <= acc_q + p_ext;
			end
		end
		if (cmd.div_step) begin
			num_q <= num_q << 1;
			if (!r2_sub[W]) begin
				rem_q <= r2_sub[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= r2[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
		if (cmd.mfin) begin
			neg_q <= sign_q;
			m_q   <= acc_q[F +: W];
			big_q <= (acc_q >> (F + W)) != '0;
		end
		if (cmd.dfin) begin
			if (kind_q == rce_pkg::K_DIV) begin
				m_q <= quo_q;
			end else begin
				m_q   <= rem_q << F;
				big_q <= (rem_q >> (W - F)) != '0;
			end
		end
		if (cmd.toq) begin
			neg_q <= t_q[W-1];
			m_q   <= mt << F;
			big_q <= (mt >> (W - F)) != '0;
		end
		if (cmd.sat) begin
			if (neg_q) begin
				if (big_q || m_q > rce_pkg::SIGN_VAL) begin
					ovf_q <= 1'b1;
					res_q <= rce_pkg::SIGN_VAL;
				end else begin
					res_q <= W'(0) - m_q;
				end
			end else begin
				if (big_q || m_q > rce_pkg::MAX_POS) begin
					ovf_q <= 1'b1;
					res_q <= rce_pkg::MAX_POS;
				end else begin
					res_q <= m_q;
				end
			end
		end
		if (cmd.out_load) begin
			out_value_q  <= rd_val;
			out_status_q <= err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			err_q       <= rce_pkg::ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.wr) begin
				vld_q[dest_q] <= 1'b1;
				if (ovf_q && err_q == rce_pkg::ST_OK) err_q <= rce_pkg::ST_OVF;
			end
			if (cmd.op && sts.zero) begin
				if (kind_q == rce_pkg::K_DIV) err_q <= rce_pkg::ST_DIV0;
				if (kind_q == rce_pkg::K_MOD) err_q <= rce_pkg::ST_MOD0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
				err_q       <= rce_pkg::ST_OK;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.kind     = kind_q;
		sts.last     = last_q;
		sts.sticky   = (err_q == rce_pkg::ST_DIV0) || (err_q == rce_pkg::ST_MOD0);
		sts.zero     = (kind_q == rce_pkg::K_DIV) ? (b_q == '0) : (ib_q == '0);
		sts.out_busy = out_valid_q;
	end

	assign out_valid   = out_valid_q;
	assign final_value = out_value_q;
	assign status      = out_status_q;
endmodule
